/* sv/eks_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eks_pkg - shared types and constants of the encoder knob supervisor
// Request and result layouts, configuration register map, mode encoding
// and the limits used by the per-encoder lanes.
// ---------------------------------------------------------------------------
package eks_pkg;

	// field widths
	localparam int CFG_W     = 12;
	localparam int THR_W     = 4;
	localparam int CNT_W     = 8;
	localparam int IDX_W     = 4;
	localparam int LANES     = 3;
	localparam int HELD_W    = 12;

	// parameter defaults
	localparam int DEF_POSITION_BITS = 4;
	localparam int DEF_TIMER_BITS    = 12;

	// jump limits and saturation
	localparam logic [3:0]       WRAP_LIMIT = 4'd8;
	localparam logic [CNT_W-1:0] FLAG_LIMIT = 8'd5;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 8'd255;

	// register reset values
	localparam logic [CFG_W-1:0] RST_INIT_WAIT  = 12'd500;
	localparam logic [CFG_W-1:0] RST_PRE_WAIT   = 12'd1000;
	localparam logic [CFG_W-1:0] RST_CMD_IVL    = 12'd500;
	localparam logic [CFG_W-1:0] RST_FAST_IVL   = 12'd100;
	localparam logic [CFG_W-1:0] RST_SLOW_IVL   = 12'd500;
	localparam logic [CFG_W-1:0] RST_CHECK_IVL  = 12'd100;
	localparam logic [CFG_W-1:0] RST_ERROR_WAIT = 12'd2000;
	localparam logic [THR_W-1:0] RST_SKIP_THR   = 4'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_INIT_WAIT  = 4'd0;
	localparam logic [IDX_W-1:0] REG_PRE_WAIT   = 4'd1;
	localparam logic [IDX_W-1:0] REG_CMD_IVL    = 4'd2;
	localparam logic [IDX_W-1:0] REG_FAST_IVL   = 4'd3;
	localparam logic [IDX_W-1:0] REG_SLOW_IVL   = 4'd4;
	localparam logic [IDX_W-1:0] REG_CHECK_IVL  = 4'd5;
	localparam logic [IDX_W-1:0] REG_ERROR_WAIT = 4'd6;
	localparam logic [IDX_W-1:0] REG_SKIP_THR   = 4'd7;

	// knob report codes
	localparam logic [1:0] KNOB_NONE = 2'd0;
	localparam logic [1:0] KNOB_MODE = 2'd1;
	localparam logic [1:0] KNOB_FULL = 2'd2;

	// supervisor modes
	typedef enum logic [1:0] {
		MODE_INIT     = 2'd0,
		MODE_PRECHECK = 2'd1,
		MODE_RUNNING  = 2'd2,
		MODE_ERROR    = 2'd3
	} mode_t;

	// one request: a millisecond tick
	typedef struct packed {
		logic [3:0] position_a;
		logic [3:0] position_b;
		logic [3:0] position_c;
		logic [2:0] buttons;
		logic       command_pending;
		logic [2:0] command_lines;
	} tick_t;

	// one result
	typedef struct packed {
		logic [1:0]        mode_now;
		logic [2:0]        common_enable;
		logic [2:0]        skip_flags;
		logic [CNT_W-1:0]  skips_a;
		logic [CNT_W-1:0]  skips_b;
		logic [CNT_W-1:0]  skips_c;
		logic [HELD_W-1:0] held_positions;
		logic [2:0]        held_buttons;
		logic [1:0]        knob_report;
		logic              flag_report;
		logic              command_taken;
	} result_t;

	// configuration registers
	typedef struct packed {
		logic [CFG_W-1:0] init_wait;
		logic [CFG_W-1:0] pre_wait;
		logic [CFG_W-1:0] cmd_ivl;
		logic [CFG_W-1:0] fast_ivl;
		logic [CFG_W-1:0] slow_ivl;
		logic [CFG_W-1:0] check_ivl;
		logic [CFG_W-1:0] error_wait;
		logic [THR_W-1:0] skip_thr;
	} cfg_t;

	// control to lanes
	typedef struct packed {
		logic load;   // precheck passed: take positions as previous
		logic check;  // skip check due this tick
	} lane_cmd_t;

	// control status for the merge stage
	typedef struct packed {
		mode_t      mode;
		logic [2:0] common;
		logic       clear_flags;
		logic [1:0] knob;
		logic       flag_rep;
		logic       taken;
	} ctrl_t;

endpackage

/* sv/eks_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eks_lane - skip checker for one encoder
// Holds the previous and accepted position, the accepted button level and
// the saturating skip count of one encoder; reports a flag set above the flag limit.
// ---------------------------------------------------------------------------
module eks_lane #(
	parameter int POSITION_BITS = eks_pkg::DEF_POSITION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  eks_pkg::lane_cmd_t         cmd,
	input  logic [POSITION_BITS-1:0]   pos,
	input  logic                       btn,
	input  logic [eks_pkg::THR_W-1:0]  thr,
	output logic [eks_pkg::CNT_W-1:0]  count_d,
	output logic [POSITION_BITS-1:0]   acc_pos_d,
	output logic                       acc_btn_d,
	output logic                       flag_set
);

	localparam int CW = POSITION_BITS + 4;

	logic [POSITION_BITS-1:0]  prev_q, prev_d;
	logic [POSITION_BITS-1:0]  acc_pos_q;
	logic                      acc_btn_q;
	logic [eks_pkg::CNT_W-1:0] count_q;
	logic [POSITION_BITS-1:0]  diff;
	logic [CW-1:0]             jump;
	logic                      skip;

	// absolute jump, large jumps are wraps
	always_comb begin
		diff = (prev_q >= pos) ? (prev_q - pos) : (pos - prev_q);
		jump = (CW'(diff) > CW'(eks_pkg::WRAP_LIMIT)) ? CW'(1) : CW'(diff);
		skip = (jump >= CW'(thr));
	end

	// next lane state
	always_comb begin
		prev_d    = prev_q;
		count_d   = count_q;
		acc_pos_d = acc_pos_q;
		acc_btn_d = acc_btn_q;
		flag_set  = 1'b0;
		if (cmd.load) begin
			prev_d = pos;
		end
		if (cmd.check) begin
			prev_d = pos;
			if (skip) begin
				count_d  = (count_q == eks_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
				flag_set = (count_d > eks_pkg::FLAG_LIMIT);
			end else begin
				acc_pos_d = pos;
				acc_btn_d = btn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			count_q   <= '0;
			acc_pos_q <= '0;
			acc_btn_q <= 1'b0;
		end else if (ce) begin
			prev_q    <= prev_d;
			count_q   <= count_d;
			acc_pos_q <= acc_pos_d;
			acc_btn_q <= acc_btn_d;
		end
	end

endmodule

/* sv/eks_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eks_ctrl - mode sequencer and phase timers
// Steps init, precheck, running and error on each tick, keeps the six
// saturating elapsed timers and the common-line drive, raises the strobes.
// ---------------------------------------------------------------------------
module eks_ctrl #(
	parameter int TIMER_BITS = eks_pkg::DEF_TIMER_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  eks_pkg::cfg_t      cfg,
	input  logic               all_zero,
	input  logic               command_pending,
	input  logic [2:0]         command_lines,
	output eks_pkg::ctrl_t     ctl,
	output eks_pkg::lane_cmd_t lane_cmd
);

	localparam int CW = (TIMER_BITS > eks_pkg::CFG_W) ? TIMER_BITS : eks_pkg::CFG_W;
	localparam logic [TIMER_BITS-1:0] TMAX = '1;

	eks_pkg::mode_t mode_q, mode_d;
	logic [TIMER_BITS-1:0] init_q, pre_q, cmd_q, fast_q, slow_q, chk_q;
	logic [TIMER_BITS-1:0] init_a, pre_a, cmd_a, fast_a, slow_a, chk_a;
	logic [TIMER_BITS-1:0] init_d, pre_d, cmd_d, fast_d, slow_d, chk_d;
	logic [2:0] common_q, common_d;
	logic init_done, pre_done, err_done;
	logic cmd_due, fast_due, slow_due, chk_due;

	// timers advance first, saturating
	always_comb begin
		init_a = (init_q == TMAX) ? init_q : init_q + 1'b1;
		pre_a  = (pre_q  == TMAX) ? pre_q  : pre_q  + 1'b1;
		cmd_a  = (cmd_q  == TMAX) ? cmd_q  : cmd_q  + 1'b1;
		fast_a = (fast_q == TMAX) ? fast_q : fast_q + 1'b1;
		slow_a = (slow_q == TMAX) ? slow_q : slow_q + 1'b1;
		chk_a  = (chk_q  == TMAX) ? chk_q  : chk_q  + 1'b1;
	end

	// phase compares
	always_comb begin
		init_done = (CW'(init_a) >  CW'(cfg.init_wait));
		pre_done  = (CW'(pre_a)  >  CW'(cfg.pre_wait));
		err_done  = (CW'(init_a) >= CW'(cfg.error_wait));
		cmd_due   = (CW'(cmd_a)  >= CW'(cfg.cmd_ivl));
		fast_due  = (CW'(fast_a) >= CW'(cfg.fast_ivl));
		slow_due  = (CW'(slow_a) >= CW'(cfg.slow_ivl));
		chk_due   = (CW'(chk_a)  >= CW'(cfg.check_ivl));
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			eks_pkg::MODE_INIT: begin
				if (init_done) mode_d = eks_pkg::MODE_PRECHECK;
			end
			eks_pkg::MODE_PRECHECK: begin
				if (pre_done) begin
					mode_d = all_zero ? eks_pkg::MODE_RUNNING : eks_pkg::MODE_ERROR;
				end
			end
			eks_pkg::MODE_RUNNING: begin
				mode_d = eks_pkg::MODE_RUNNING;
			end
			eks_pkg::MODE_ERROR: begin
				if (err_done) mode_d = eks_pkg::MODE_INIT;
			end
			default: begin
				mode_d = eks_pkg::MODE_INIT;
			end
		endcase
	end

	// timer clears, drive and strobes
	always_comb begin
		init_d = init_a;
		pre_d  = pre_a;
		cmd_d  = cmd_a;
		fast_d = fast_a;
		slow_d = slow_a;
		chk_d  = chk_a;
		common_d = common_q;
		ctl.clear_flags = 1'b0;
		ctl.knob     = eks_pkg::KNOB_NONE;
		ctl.flag_rep = 1'b0;
		ctl.taken    = 1'b0;
		lane_cmd.load  = 1'b0;
		lane_cmd.check = 1'b0;
		case (mode_q)
			eks_pkg::MODE_INIT: begin
				if (init_done) begin
					ctl.knob = eks_pkg::KNOB_MODE;
					pre_d = '0;
				end
			end
			eks_pkg::MODE_PRECHECK: begin
				common_d = '0;
				if (pre_done) begin
					ctl.knob = eks_pkg::KNOB_MODE;
					if (!all_zero) begin
						init_d = '0;
					end else begin
						common_d = 3'b111;
						lane_cmd.load = 1'b1;
						ctl.clear_flags = 1'b1;
						cmd_d  = '0;
						fast_d = '0;
						slow_d = '0;
						chk_d  = '0;
					end
				end
			end
			eks_pkg::MODE_RUNNING: begin
				if (cmd_due) begin
					if (command_pending) begin
						common_d  = command_lines;
						ctl.taken = 1'b1;
					end
					cmd_d = '0;
				end
				if (fast_due) begin
					ctl.knob = eks_pkg::KNOB_FULL;
					fast_d = '0;
				end
				if (slow_due) begin
					ctl.flag_rep = 1'b1;
					slow_d = '0;
				end
				if (chk_due) begin
					lane_cmd.check = 1'b1;
					chk_d = '0;
				end
			end
			eks_pkg::MODE_ERROR: begin
				if (err_done) begin
					init_d = '0;
					ctl.knob = eks_pkg::KNOB_MODE;
				end
			end
			default: begin
				ctl.knob = eks_pkg::KNOB_NONE;
			end
		endcase
		ctl.mode   = mode_d;
		ctl.common = common_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= eks_pkg::MODE_INIT;
			init_q   <= '0;
			pre_q    <= '0;
			cmd_q    <= '0;
			fast_q   <= '0;
			slow_q   <= '0;
			chk_q    <= '0;
			common_q <= '0;
		end else if (ce) begin
			mode_q   <= mode_d;
			init_q   <= init_d;
			pre_q    <= pre_d;
			cmd_q    <= cmd_d;
			fast_q   <= fast_d;
			slow_q   <= slow_d;
			chk_q    <= chk_d;
			common_q <= common_d;
		end
	end

endmodule

/* sv/encoder_knob_supervisor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_knob_supervisor - supervisor for three position encoders
// Mode sequencing, periodic reports and skip counting per millisecond tick.
// ---------------------------------------------------------------------------
// Each request is one tick and yields exactly one result, which is captured in
// the output register as the request is taken. A request can be taken every
// cycle: the three encoder lanes and the mode sequencer update their state as
// the tick is taken, and the output register only holds the tick back
// while its own result is stalled. Configuration writes are always ready;
// write them while no tick is in flight.
module encoder_knob_supervisor #(
	parameter int POSITION_BITS = eks_pkg::DEF_POSITION_BITS,
	parameter int TIMER_BITS    = eks_pkg::DEF_TIMER_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_valid,
	output logic                       tick_stall,
	input  eks_pkg::tick_t             tick,
	output logic                       result_valid,
	input  logic                       result_stall,
	output eks_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [eks_pkg::IDX_W-1:0]  cfg_index,
	input  logic [eks_pkg::CFG_W-1:0]  cfg_data
);

	eks_pkg::cfg_t      cfg_q;
	eks_pkg::ctrl_t     ctl;
	eks_pkg::lane_cmd_t lane_cmd;
	eks_pkg::result_t   result_d, result_q;
	logic               result_valid_q;
	logic               accept;
	logic               all_zero;
	logic [2:0]         flags_q, flags_d, flag_set;
	logic [POSITION_BITS-1:0]  pos     [eks_pkg::LANES];
	logic [POSITION_BITS-1:0]  acc_pos [eks_pkg::LANES];
	logic [eks_pkg::CNT_W-1:0] count   [eks_pkg::LANES];
	logic [2:0]                acc_btn;
	logic [eks_pkg::LANES*POSITION_BITS-1:0] held_w;

	// handshake: output register decouples the two sides
	assign tick_stall   = result_valid_q && result_stall;
	assign accept       = tick_valid && !tick_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_wait  <= eks_pkg::RST_INIT_WAIT;
			cfg_q.pre_wait   <= eks_pkg::RST_PRE_WAIT;
			cfg_q.cmd_ivl    <= eks_pkg::RST_CMD_IVL;
			cfg_q.fast_ivl   <= eks_pkg::RST_FAST_IVL;
			cfg_q.slow_ivl   <= eks_pkg::RST_SLOW_IVL;
			cfg_q.check_ivl  <= eks_pkg::RST_CHECK_IVL;
			cfg_q.error_wait <= eks_pkg::RST_ERROR_WAIT;
			cfg_q.skip_thr   <= eks_pkg::RST_SKIP_THR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				eks_pkg::REG_INIT_WAIT:  cfg_q.init_wait  <= cfg_data;
				eks_pkg::REG_PRE_WAIT:   cfg_q.pre_wait   <= cfg_data;
				eks_pkg::REG_CMD_IVL:    cfg_q.cmd_ivl    <= cfg_data;
				eks_pkg::REG_FAST_IVL:   cfg_q.fast_ivl   <= cfg_data;
				eks_pkg::REG_SLOW_IVL:   cfg_q.slow_ivl   <= cfg_data;
				eks_pkg::REG_CHECK_IVL:  cfg_q.check_ivl  <= cfg_data;
				eks_pkg::REG_ERROR_WAIT: cfg_q.error_wait <= cfg_data;
				eks_pkg::REG_SKIP_THR:   cfg_q.skip_thr   <= cfg_data[eks_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// positions at lane width
	always_comb begin
		pos[0]   = POSITION_BITS'(tick.position_a);
		pos[1]   = POSITION_BITS'(tick.position_b);
		pos[2]   = POSITION_BITS'(tick.position_c);
		all_zero = (pos[0] == '0) && (pos[1] == '0) && (pos[2] == '0);
	end

	eks_ctrl #(
		.TIMER_BITS (TIMER_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.ce              (accept),
		.cfg             (cfg_q),
		.all_zero        (all_zero),
		.command_pending (tick.command_pending),
		.command_lines   (tick.command_lines),
		.ctl             (ctl),
		.lane_cmd        (lane_cmd)
	);

	// one checker lane per encoder
	for (genvar i = 0; i < eks_pkg::LANES; i++) begin : g_lane
		eks_lane #(
			.POSITION_BITS (POSITION_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ce        (accept),
			.cmd       (lane_cmd),
			.pos       (pos[i]),
			.btn       (tick.buttons[i]),
			.thr       (cfg_q.skip_thr),
			.count_d   (count[i]),
			.acc_pos_d (acc_pos[i]),
			.acc_btn_d (acc_btn[i]),
			.flag_set  (flag_set[i])
		);
		assign held_w[i*POSITION_BITS +: POSITION_BITS] = acc_pos[i];
	end

	// merge: flags and result word
	always_comb begin
		flags_d = ctl.clear_flags ? 3'b000 : (flags_q | flag_set);
		result_d.mode_now       = ctl.mode;
		result_d.common_enable  = ctl.common;
		result_d.skip_flags     = flags_d;
		result_d.skips_a        = count[0];
		result_d.skips_b        = count[1];
		result_d.skips_c        = count[2];
		result_d.held_positions = eks_pkg::HELD_W'(held_w);
		result_d.held_buttons   = acc_btn;
		result_d.knob_report    = ctl.knob;
		result_d.flag_report    = ctl.flag_rep;
		result_d.command_taken  = ctl.taken;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				flags_q <= flags_d;
			end
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> result_valid)
		else $error("tick stalled with empty output register");

	a_flag_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((!result.skip_flags[0] || result.skips_a > eks_pkg::FLAG_LIMIT) &&
		                  (!result.skip_flags[1] || result.skips_b > eks_pkg::FLAG_LIMIT) &&
		                  (!result.skip_flags[2] || result.skips_c > eks_pkg::FLAG_LIMIT)))
		else $error("skip flag set below flag limit");

	a_run_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mode_now != eks_pkg::MODE_RUNNING) |->
		(result.knob_report != eks_pkg::KNOB_FULL && !result.command_taken &&
		 !result.flag_report))
		else $error("running strobe outside running mode");

	a_precheck_commons: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.mode_now == eks_pkg::MODE_PRECHECK) |->
		(result.common_enable == 3'b000))
		else $error("commons driven during precheck");

endmodule
